### sv/bnms_pkg.sv
// ----------------------------------------------------------------------------
// bnms_pkg
// Shared types and constants for the 3D box suppression block.
// ----------------------------------------------------------------------------
package bnms_pkg;

  localparam int unsigned CMP_DEPTH = 6;
  localparam int unsigned COUNT_W = 7;
  localparam logic [15:0] THR_RESET = 16'd32768;

  typedef logic signed [18:0] edge_t;

  typedef struct packed {
    logic [15:0] center_z;
    logic [15:0] center_y;
    logic [15:0] center_x;
    logic [15:0] size_d;
    logic [15:0] size_h;
    logic [15:0] size_w;
    logic [47:0] volume;
    logic [15:0] box_id;
    logic        is_last;
  } box_in_t;

  typedef struct packed {
    logic [15:0]        kept_id;
    logic               last_kept;
    logic [COUNT_W-1:0] kept_count;
    logic               overflow;
  } kept_out_t;

  typedef struct packed {
    edge_t [2:0] lo;
    edge_t [2:0] hi;
    logic [47:0] vol;
    logic [15:0] id;
  } box_t;

endpackage

### sv/box_nms_3d.sv
// Boxes load at one per cycle. After the last box, the block makes (kept + 1)
// passes around the box ring and then registers the final beat; stalls on
// the output can hold it.
// Throughput: one box set at a time; input stalls from the last box until the
// final kept beat is registered. The ring shift and the 6-stage overlap
// pipeline set the pass length. Reset clears all live flags, counts and the
// threshold (to 0.5) at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// box_nms_3d
// Greedy 3D non-maximum suppression over a ring of box cells.
// ----------------------------------------------------------------------------
module box_nms_3d #(
  parameter int unsigned MAX_BOXES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bnms_pkg::box_in_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bnms_pkg::kept_out_t  out_data_o
);

  localparam int unsigned PASS_LEN = MAX_BOXES + bnms_pkg::CMP_DEPTH;
  localparam int unsigned CW = $clog2(PASS_LEN);
  localparam int unsigned LW = $clog2(MAX_BOXES + 1);

  typedef enum logic [1:0] {ST_LOAD, ST_RUN, ST_DONE} state_e;

  state_e                        state_q;
  logic [LW-1:0]                 loaded_q;
  logic                          ovf_q;
  logic [bnms_pkg::COUNT_W-1:0]  kept_q;
  logic                          pend_v_q;
  logic [15:0]                   pend_id_q;
  logic                          have_ref_q;
  bnms_pkg::box_t                ref_q;
  logic [CW-1:0]                 cnt_q;
  logic                          out_v_q;
  bnms_pkg::kept_out_t           out_q;
  logic [15:0]                   thr_q;

  logic [MAX_BOXES-1:0]          c_valid;
  bnms_pkg::box_t                c_data [MAX_BOXES];
  logic                          cmp_valid;
  bnms_pkg::box_t                cmp_data;
  bnms_pkg::box_t                new_box;
  logic                          in_acc, load_shift, out_free;
  logic                          cap_want, cap, adv, pass_end, cell_en;
  logic                          tail_valid;
  bnms_pkg::box_t                tail_data;

  assign in_stall_o = (state_q != ST_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_shift = in_acc && (loaded_q < LW'(MAX_BOXES));
  assign out_free   = !out_v_q || !out_stall_i;
  assign cap_want   = c_valid[0] && !have_ref_q;
  assign adv        = (state_q == ST_RUN) && !(cap_want && pend_v_q && !out_free);
  assign cap        = adv && cap_want;
  assign pass_end   = adv && (cnt_q == CW'(PASS_LEN - 1));
  assign cell_en    = adv || load_shift;

  assign new_box.lo[0] = $signed({2'b00, in_data_i.center_z, 1'b0})
                       - $signed({3'b000, in_data_i.size_d});
  assign new_box.lo[1] = $signed({2'b00, in_data_i.center_y, 1'b0})
                       - $signed({3'b000, in_data_i.size_h});
  assign new_box.lo[2] = $signed({2'b00, in_data_i.center_x, 1'b0})
                       - $signed({3'b000, in_data_i.size_w});
  assign new_box.hi[0] = $signed({2'b00, in_data_i.center_z, 1'b0})
                       + $signed({3'b000, in_data_i.size_d});
  assign new_box.hi[1] = $signed({2'b00, in_data_i.center_y, 1'b0})
                       + $signed({3'b000, in_data_i.size_h});
  assign new_box.hi[2] = $signed({2'b00, in_data_i.center_x, 1'b0})
                       + $signed({3'b000, in_data_i.size_w});
  assign new_box.vol   = in_data_i.volume;
  assign new_box.id    = in_data_i.box_id;

  assign tail_valid = (state_q == ST_LOAD) ? 1'b1 : cmp_valid;
  assign tail_data  = (state_q == ST_LOAD) ? new_box : cmp_data;

  for (genvar g = 0; g < MAX_BOXES; g++) begin : g_cell
    if (g == MAX_BOXES - 1) begin : g_tail
      bnms_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (cell_en),
        .valid_i (tail_valid),
        .data_i  (tail_data),
        .valid_o (c_valid[g]),
        .data_o  (c_data[g])
      );
    end else begin : g_body
      bnms_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (cell_en),
        .valid_i (c_valid[g+1]),
        .data_i  (c_data[g+1]),
        .valid_o (c_valid[g]),
        .data_o  (c_data[g])
      );
    end
  end

  bnms_cmp u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .thr_i   (thr_q),
    .ref_i   (ref_q),
    .valid_i (c_valid[0] && have_ref_q),
    .data_i  (c_data[0]),
    .valid_o (cmp_valid),
    .data_o  (cmp_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      loaded_q   <= '0;
      ovf_q      <= 1'b0;
      kept_q     <= '0;
      pend_v_q   <= 1'b0;
      pend_id_q  <= '0;
      have_ref_q <= 1'b0;
      ref_q      <= '0;
      cnt_q      <= '0;
      out_v_q    <= 1'b0;
      out_q      <= '0;
      thr_q      <= bnms_pkg::THR_RESET;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            if (load_shift) begin
              loaded_q <= loaded_q + 1'b1;
            end else begin
              ovf_q <= 1'b1;
            end
            if (in_data_i.is_last) begin
              state_q <= ST_RUN;
              cnt_q   <= '0;
            end
          end
        end
        ST_RUN: begin
          if (adv) begin
            cnt_q <= pass_end ? '0 : cnt_q + 1'b1;
          end
          if (cap) begin
            have_ref_q <= 1'b1;
            ref_q      <= c_data[0];
            pend_id_q  <= c_data[0].id;
            pend_v_q   <= 1'b1;
            kept_q     <= kept_q + 1'b1;
            if (pend_v_q) begin
              out_v_q <= 1'b1;
              out_q   <= '{kept_id: pend_id_q, last_kept: 1'b0, kept_count: '0,
                           overflow: ovf_q};
            end
          end
          if (pass_end) begin
            have_ref_q <= 1'b0;
            if (!(have_ref_q || cap)) begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            if (pend_v_q) begin
              out_v_q <= 1'b1;
              out_q   <= '{kept_id: pend_id_q, last_kept: 1'b1, kept_count: kept_q,
                           overflow: ovf_q};
            end
            state_q  <= ST_LOAD;
            loaded_q <= '0;
            ovf_q    <= 1'b0;
            kept_q   <= '0;
            pend_v_q <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_loaded_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q <= LW'(MAX_BOXES))
    else $error("loaded count beyond capacity");

  a_kept_le_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (LW'(kept_q) <= loaded_q))
    else $error("more kept boxes than loaded");

  a_ring_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (c_valid == '0))
    else $error("live box left in ring at end of set");

  a_last_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.last_kept) |-> (out_q.kept_count != '0))
    else $error("final beat with zero count");
`endif

endmodule

### sv/bnms_cell.sv
// ----------------------------------------------------------------------------
// bnms_cell
// One storage cell of the box ring: holds a box and its live flag, takes
// its neighbor's content on every advance.
// ----------------------------------------------------------------------------
module bnms_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  bnms_pkg::box_t  data_i,
  output logic            valid_o,
  output bnms_pkg::box_t  data_o
);

  logic           valid_q;
  bnms_pkg::box_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### sv/bnms_cmp.sv
// ----------------------------------------------------------------------------
// bnms_cmp
// Overlap pipeline of the box ring: compares each passing box against the
// reference box and drops its live flag when the IoU reaches the threshold.
// ----------------------------------------------------------------------------
module bnms_cmp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [15:0]     thr_i,
  input  bnms_pkg::box_t  ref_i,
  input  logic            valid_i,
  input  bnms_pkg::box_t  data_i,
  output logic            valid_o,
  output bnms_pkg::box_t  data_o
);

  typedef struct packed {
    logic [2:0][16:0] len;
    logic [48:0]      vsum;
  } st1_t;

  typedef struct packed {
    logic [16:0] len2;
    logic [33:0] p01;
    logic [48:0] vsum;
  } st2_t;

  typedef struct packed {
    logic [50:0] inter;
    logic [48:0] vsum;
  } st3_t;

  typedef struct packed {
    logic [50:0] inter;
    logic        pos;
    logic [51:0] uni;
  } st4_t;

  typedef struct packed {
    logic [50:0] inter;
    logic        pos;
    logic [41:0] pp_lo;
    logic [41:0] pp_hi;
  } st5_t;

  logic [5:0]           v_q;
  bnms_pkg::box_t [5:0] b_q;
  st1_t                 s1_q, s1_d;
  st2_t                 s2_q, s2_d;
  st3_t                 s3_q, s3_d;
  st4_t                 s4_q, s4_d;
  st5_t                 s5_q, s5_d;
  logic signed [52:0]   uni;
  logic [67:0]          rhs;
  logic [67:0]          lhs;

  always_comb begin
    bnms_pkg::edge_t    mx;
    bnms_pkg::edge_t    mn;
    logic signed [19:0] diff;
    s1_d.vsum = {1'b0, ref_i.vol} + {1'b0, b_q[0].vol};
    for (int k = 0; k < 3; k++) begin
      mx = (ref_i.lo[k] > b_q[0].lo[k]) ? ref_i.lo[k] : b_q[0].lo[k];
      mn = (ref_i.hi[k] < b_q[0].hi[k]) ? ref_i.hi[k] : b_q[0].hi[k];
      diff = $signed({mn[18], mn}) - $signed({mx[18], mx});
      s1_d.len[k] = diff[19] ? 17'd0 : diff[16:0];
    end
  end

  assign s2_d.len2 = s1_q.len[2];
  assign s2_d.p01  = s1_q.len[0] * s1_q.len[1];
  assign s2_d.vsum = s1_q.vsum;

  assign s3_d.inter = 51'(s2_q.p01 * s2_q.len2);
  assign s3_d.vsum  = s2_q.vsum;

  assign uni = $signed({1'b0, s3_q.vsum, 3'b000}) - $signed({2'b00, s3_q.inter});
  assign s4_d.inter = s3_q.inter;
  assign s4_d.pos   = !uni[52] && (uni != 53'sd0);
  assign s4_d.uni   = uni[51:0];

  assign s5_d.inter = s4_q.inter;
  assign s5_d.pos   = s4_q.pos;
  assign s5_d.pp_lo = thr_i * s4_q.uni[25:0];
  assign s5_d.pp_hi = thr_i * s4_q.uni[51:26];

  assign rhs = {s5_q.pp_hi, 26'd0} + {26'd0, s5_q.pp_lo};
  assign lhs = {1'b0, s5_q.inter, 16'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_q  <= {b_q[4:0], data_i};
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
      s5_q <= s5_d;
    end
  end

  assign valid_o = v_q[5] && !(s5_q.pos && (lhs >= rhs));
  assign data_o  = b_q[5];

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for box_nms_3d. Box sets with random and directed
// geometry are sent through the input channel. A scoreboard runs the greedy
// IoU suppression on its own copy of each set and compares every kept-box
// beat field by field. Both channels idle at random, and the threshold is
// changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CAP = 64;

  class nms_tracker;
    longint    lo_e[CAP][3];
    longint    hi_e[CAP][3];
    longint    vols[CAP];
    logic [15:0] ids[CAP];
    int        loaded;
    bit        ovf;
    logic [15:0] thr;
    bnms_pkg::kept_out_t kept_q[$];
    int        errors;
    int        beats;
    int        sets;

    function new();
      loaded = 0;
      ovf = 0;
      thr = bnms_pkg::THR_RESET;
      errors = 0;
      beats = 0;
      sets = 0;
    endfunction

    function bit suppresses(int a, int b);
      longint lo, hi, len, uni;
      logic [63:0] inter;
      logic [79:0] lhs, rhs;
      inter = 1;
      for (int k = 0; k < 3; k++) begin
        lo = (lo_e[a][k] > lo_e[b][k]) ? lo_e[a][k] : lo_e[b][k];
        hi = (hi_e[a][k] < hi_e[b][k]) ? hi_e[a][k] : hi_e[b][k];
        len = hi - lo;
        if (len < 0) len = 0;
        inter = inter * len;
      end
      uni = 8 * vols[a] + 8 * vols[b] - longint'(inter);
      if (uni <= 0) return 0;
      lhs = {inter, 16'h0};
      rhs = 80'(thr) * 80'(uni);
      return lhs >= rhs;
    endfunction

    function void add_box(bnms_pkg::box_in_t b);
      bit sup[CAP];
      int n;
      bnms_pkg::kept_out_t r;
      if (loaded < CAP) begin
        lo_e[loaded][0] = 2 * longint'(b.center_z) - longint'(b.size_d);
        hi_e[loaded][0] = 2 * longint'(b.center_z) + longint'(b.size_d);
        lo_e[loaded][1] = 2 * longint'(b.center_y) - longint'(b.size_h);
        hi_e[loaded][1] = 2 * longint'(b.center_y) + longint'(b.size_h);
        lo_e[loaded][2] = 2 * longint'(b.center_x) - longint'(b.size_w);
        hi_e[loaded][2] = 2 * longint'(b.center_x) + longint'(b.size_w);
        vols[loaded] = longint'(b.volume);
        ids[loaded] = b.box_id;
        loaded++;
      end else begin
        ovf = 1;
      end
      if (!b.is_last) return;
      n = 0;
      for (int i = 0; i < CAP; i++) sup[i] = 0;
      for (int i = 0; i < loaded; i++) begin
        if (sup[i]) continue;
        r.kept_id = ids[i];
        r.last_kept = 0;
        r.kept_count = '0;
        r.overflow = ovf;
        kept_q.push_back(r);
        n++;
        for (int j = i + 1; j < loaded; j++)
          if (!sup[j] && suppresses(i, j)) sup[j] = 1;
      end
      r = kept_q.pop_back();
      r.last_kept = 1;
      r.kept_count = bnms_pkg::COUNT_W'(n);
      kept_q.push_back(r);
      loaded = 0;
      ovf = 0;
      sets++;
    endfunction

    function void check_kept(bnms_pkg::kept_out_t got);
      bnms_pkg::kept_out_t exp_r;
      beats++;
      if (kept_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: id %0d", got.kept_id);
        return;
      end
      exp_r = kept_q.pop_front();
      if (got.kept_id !== exp_r.kept_id || got.last_kept !== exp_r.last_kept ||
          got.kept_count !== exp_r.kept_count || got.overflow !== exp_r.overflow) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: exp id %0d last %0d cnt %0d ovf %0d, ",
                    "got id %0d last %0d cnt %0d ovf %0d"},
                   exp_r.kept_id, exp_r.last_kept, exp_r.kept_count, exp_r.overflow,
                   got.kept_id, got.last_kept, got.kept_count, got.overflow);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  logic [15:0] cfg_wdata;
  logic      in_valid;
  logic      in_stall;
  bnms_pkg::box_in_t   in_data;
  logic      out_valid;
  logic      out_stall;
  bnms_pkg::kept_out_t out_data;
  bit        tx_busy_mode;
  bit        rx_busy_mode;
  nms_tracker sb;

  box_nms_3d #(.MAX_BOXES(CAP)) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic send_box(bnms_pkg::box_in_t b);
    int gap;
    gap = tx_busy_mode ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    sb.add_box(b);
  endtask

  task automatic drain();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (sb.kept_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_thr(logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.thr = v;
  endtask

  function automatic bnms_pkg::box_in_t make_box(logic [15:0] cz, logic [15:0] cy,
                                                 logic [15:0] cx, logic [15:0] d,
                                                 logic [15:0] h, logic [15:0] w,
                                                 logic [15:0] id, logic last);
    bnms_pkg::box_in_t b;
    b.center_z = cz;
    b.center_y = cy;
    b.center_x = cx;
    b.size_d = d;
    b.size_h = h;
    b.size_w = w;
    b.volume = 48'(d) * 48'(h) * 48'(w);
    b.box_id = id;
    b.is_last = last;
    return b;
  endfunction

  function automatic bnms_pkg::box_in_t near_box(logic [15:0] base, logic last);
    bnms_pkg::box_in_t b;
    b = make_box(base + 16'($urandom_range(0, 256)), base + 16'($urandom_range(0, 256)),
                 base + 16'($urandom_range(0, 256)), 16'($urandom_range(64, 1024)),
                 16'($urandom_range(64, 1024)), 16'($urandom_range(64, 1024)),
                 16'($urandom), last);
    return b;
  endfunction

  function automatic bnms_pkg::box_in_t noise_box(logic last);
    bnms_pkg::box_in_t b;
    b.center_z = 16'($urandom);
    b.center_y = 16'($urandom);
    b.center_x = 16'($urandom);
    b.size_d = 16'($urandom);
    b.size_h = 16'($urandom);
    b.size_w = 16'($urandom);
    b.volume = {16'($urandom), 32'($urandom)};
    b.box_id = 16'($urandom);
    b.is_last = last;
    return b;
  endfunction

  task automatic send_set(int n, int noise_pct);
    logic [15:0] base;
    base = 16'($urandom_range(0, 60000));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise_pct) send_box(noise_box(i == n - 1));
      else send_box(near_box(base, i == n - 1));
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    tx_busy_mode = 1'b1;
    rx_busy_mode = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero-volume pair, identical boxes, offset box, disjoint box, extreme box
    send_box(make_box(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0000, 1'b0));
    send_box(make_box(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hffff, 1'b0));
    send_box(make_box(16'd1000, 16'd1000, 16'd1000, 16'd400, 16'd400, 16'd400,
                      16'h0001, 1'b0));
    send_box(make_box(16'd1000, 16'd1000, 16'd1000, 16'd400, 16'd400, 16'd400,
                      16'h0002, 1'b0));
    send_box(make_box(16'd1100, 16'd1000, 16'd1000, 16'd400, 16'd400, 16'd400,
                      16'h0003, 1'b0));
    send_box(make_box(16'd9000, 16'd9000, 16'd9000, 16'd100, 16'd100, 16'd100,
                      16'h0004, 1'b0));
    send_box(make_box(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                      16'h8000, 1'b1));
    send_box(make_box(16'd500, 16'd500, 16'd500, 16'd10, 16'd10, 16'd10, 16'h1234, 1'b1));

    write_thr(16'h0000);
    send_box(make_box(16'd100, 16'd100, 16'd100, 16'd20, 16'd20, 16'd20, 16'd10, 1'b0));
    send_box(make_box(16'd5000, 16'd5000, 16'd5000, 16'd20, 16'd20, 16'd20, 16'd11, 1'b0));
    send_box(make_box(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd12, 1'b1));

    write_thr(16'hffff);
    send_box(make_box(16'd300, 16'd300, 16'd300, 16'd50, 16'd50, 16'd50, 16'd20, 1'b0));
    send_box(make_box(16'd300, 16'd300, 16'd300, 16'd50, 16'd50, 16'd50, 16'd21, 1'b0));
    send_box(make_box(16'd301, 16'd300, 16'd300, 16'd50, 16'd50, 16'd50, 16'd22, 1'b1));

    write_thr(16'($urandom));
    for (int s = 0; s < 6; s++) send_set($urandom_range(1, 8), 15);

    tx_busy_mode = 1'b0;
    rx_busy_mode = 1'b0;
    for (int s = 0; s < 3; s++) send_set($urandom_range(2, 6), 10);
    drain();
    tx_busy_mode = 1'b1;
    rx_busy_mode = 1'b1;

    write_thr(16'h8000);
    send_set(CAP + 2, 30);
    for (int s = 0; s < 5; s++) send_set($urandom_range(1, 6), 20);

    drain();
    $display("%0d sets, %0d kept beats checked, thresholds 0 to 0xffff, overflow set included",
             sb.sets, sb.beats);
    if (sb.errors == 0 && sb.kept_q.size() == 0) begin
      $display("PASS box_nms_3d");
    end else begin
      $display("%0d mismatches, %0d beats outstanding", sb.errors, sb.kept_q.size());
      $display("FAIL box_nms_3d");
    end
    $finish;
  end

  initial begin
    int wait_n;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      wait_n = rx_busy_mode ? $urandom_range(0, 4) : 0;
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_kept(out_data);
    end
  end

  initial begin
    #20000000;
    $display("FAIL box_nms_3d");
    $finish;
  end

endmodule
